// ----- rtl/msl_pkg.sv -----
// ----------------------------------------------------------------------------
// msl_pkg: shared types and helpers of the mailbox separator line classifier
// Parse phases, verdict codes and the character tests used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package msl_pkg;

  // Parse position within a line, one-hot
  typedef enum logic [27:0] {
    PH_START     = 28'd1 << 0,
    PH_FROM      = 28'd1 << 1,
    PH_ART       = 28'd1 << 2,
    PH_ADDR_SP   = 28'd1 << 3,
    PH_ADDR      = 28'd1 << 4,
    PH_ADDR_POST = 28'd1 << 5,
    PH_WDAY      = 28'd1 << 6,
    PH_WDAY_SP   = 28'd1 << 7,
    PH_MON       = 28'd1 << 8,
    PH_MON_SP    = 28'd1 << 9,
    PH_DAY_DIG   = 28'd1 << 10,
    PH_DAY_SP    = 28'd1 << 11,
    PH_TIME      = 28'd1 << 12,
    PH_ZY        = 28'd1 << 13,
    PH_ZONE      = 28'd1 << 14,
    PH_ZONE_SP   = 28'd1 << 15,
    PH_YEAR      = 28'd1 << 16,
    PH_TZ        = 28'd1 << 17,
    PH_TZ2       = 28'd1 << 18,
    PH_TAIL      = 28'd1 << 19,
    PH_ART_SP    = 28'd1 << 20,
    PH_NUM       = 28'd1 << 21,
    PH_NUM_SP    = 28'd1 << 22,
    PH_OF        = 28'd1 << 23,
    PH_GRP_SP    = 28'd1 << 24,
    PH_GRP       = 28'd1 << 25,
    PH_COLON     = 28'd1 << 26,
    PH_DONE      = 28'd1 << 27
  } phase_t;

  typedef enum logic [1:0] {
    K_LINE = 2'd0,
    K_MAIL = 2'd1,
    K_NEWS = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    R_OK     = 4'd0,
    R_PREFIX = 4'd1,
    R_WDAY   = 4'd2,
    R_MONTH  = 4'd3,
    R_DAY    = 4'd4,
    R_TIME   = 4'd5,
    R_YEAR   = 4'd6,
    R_EXTRA  = 4'd7,
    R_NUMBER = 4'd8,
    R_OF     = 4'd9,
    R_COLON  = 4'd10
  } reason_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c inside {["A":"Z"]};
  endfunction

  // Expected characters of "From ", position 0 already taken by the start phase
  function automatic logic [7:0] mail_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "F";
      3'd1:    c = "r";
      3'd2:    c = "o";
      3'd3:    c = "m";
      3'd4:    c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] news_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "A";
      3'd1:    c = "r";
      3'd2:    c = "t";
      3'd3:    c = "i";
      3'd4:    c = "c";
      3'd5:    c = "l";
      3'd6:    c = "e";
      default: c = " ";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] of_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "o";
      2'd1:    c = "f";
      2'd2:    c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic day_match(input logic [15:0] pfx, input logic [7:0] c);
    return {pfx, c} inside {"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
  endfunction

  function automatic logic mon_match(input logic [15:0] pfx, input logic [7:0] c);
    return {pfx, c} inside {"Jan", "Feb", "Mar", "Apr", "May", "Jun",
                            "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mailbox_separator_line_classifier_core.sv -----
// ----------------------------------------------------------------------------
// mailbox_separator_line_classifier_core: mail / news separator line check
// Parses a line one byte per transaction and gives a verdict at its last byte.
// ----------------------------------------------------------------------------
// The verdict is registered and valid in the cycle after the transaction marked last.
// Throughput: one input transaction per cycle while the input is not stalled; the
//   parse step is a single next-state update of the phase register feeding the result register.
// Input is stalled only while a verdict waits and the output is stalled.
// Reset (rst, synchronous) returns the parser to line start, drops any verdict.
`default_nettype none

module mailbox_separator_line_classifier_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] ch,
  input  wire logic       last,
  input  wire logic       empty_req,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [3:0]      reason
);

  msl_pkg::phase_t  phase, phase_next;
  logic [3:0]       sub_count, sub_count_next;
  logic [15:0]      name_prefix, name_prefix_next;
  msl_pkg::reason_t failure, failure_next;
  logic             text_ended, text_ended_next;

  msl_pkg::reason_t fail_code;
  msl_pkg::kind_t   res_kind;
  msl_pkg::reason_t res_reason;
  logic [3:0]       sub_inc;
  logic             in_acc;

  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign sub_inc  = sub_count + 4'd1;

  always_comb begin
    phase_next       = phase;
    sub_count_next   = sub_count;
    name_prefix_next = name_prefix;
    failure_next     = failure;
    text_ended_next  = text_ended;
    fail_code        = msl_pkg::R_OK;
    res_kind         = msl_pkg::K_LINE;
    res_reason       = msl_pkg::R_PREFIX;

    if (in_acc && !empty_req && !text_ended) begin
      if (ch == 8'h00) begin
        text_ended_next = 1'b1;
      end else begin
        case (phase)
          msl_pkg::PH_START: begin
            if (ch == "F") begin
              phase_next = msl_pkg::PH_FROM;
              sub_count_next = 4'd1;
            end else if (ch == "A") begin
              phase_next = msl_pkg::PH_ART;
              sub_count_next = 4'd1;
            end else begin
              fail_code = msl_pkg::R_PREFIX;
            end
          end
          msl_pkg::PH_FROM: begin
            if (ch == msl_pkg::mail_char(sub_count[2:0])) begin
              sub_count_next = sub_inc;
              if (sub_inc >= 4'd5) phase_next = msl_pkg::PH_ADDR_SP;
            end else begin
              fail_code = msl_pkg::R_PREFIX;
            end
          end
          msl_pkg::PH_ART: begin
            if (ch == msl_pkg::news_char(sub_count[2:0])) begin
              sub_count_next = sub_inc;
              if (sub_inc >= 4'd8) phase_next = msl_pkg::PH_ART_SP;
            end else begin
              fail_code = msl_pkg::R_PREFIX;
            end
          end
          msl_pkg::PH_ADDR_SP: begin
            if (ch != " ") phase_next = msl_pkg::PH_ADDR;
          end
          msl_pkg::PH_ADDR: begin
            if (ch == " ") phase_next = msl_pkg::PH_ADDR_POST;
          end
          msl_pkg::PH_ADDR_POST: begin
            // first weekday letter lands here
            if (ch != " ") begin
              phase_next = msl_pkg::PH_WDAY;
              name_prefix_next[15:8] = ch;
              sub_count_next = 4'd1;
            end
          end
          msl_pkg::PH_WDAY, msl_pkg::PH_MON: begin
            if (sub_count == 4'd0) begin
              name_prefix_next[15:8] = ch;
              sub_count_next = 4'd1;
            end else if (sub_count == 4'd1) begin
              name_prefix_next[7:0] = ch;
              sub_count_next = 4'd2;
            end else if (phase == msl_pkg::PH_WDAY) begin
              if (msl_pkg::day_match(name_prefix, ch)) phase_next = msl_pkg::PH_WDAY_SP;
              else fail_code = msl_pkg::R_WDAY;
            end else begin
              if (msl_pkg::mon_match(name_prefix, ch)) phase_next = msl_pkg::PH_MON_SP;
              else fail_code = msl_pkg::R_MONTH;
            end
          end
          msl_pkg::PH_WDAY_SP: begin
            if (ch != " ") begin
              phase_next = msl_pkg::PH_MON;
              name_prefix_next[15:8] = ch;
              sub_count_next = 4'd1;
            end
          end
          msl_pkg::PH_MON_SP: begin
            if (ch != " ") begin
              if (msl_pkg::is_digit(ch)) phase_next = msl_pkg::PH_DAY_DIG;
              else fail_code = msl_pkg::R_DAY;
            end
          end
          msl_pkg::PH_DAY_DIG: begin
            // a digit continues the day; any other non-space character fails as a time error
            if (ch == " ") phase_next = msl_pkg::PH_DAY_SP;
            else if (!msl_pkg::is_digit(ch)) fail_code = msl_pkg::R_TIME;
          end
          msl_pkg::PH_DAY_SP: begin
            if (ch != " ") begin
              if (msl_pkg::is_digit(ch)) begin
                phase_next = msl_pkg::PH_TIME;
                sub_count_next = 4'd1;
              end else begin
                fail_code = msl_pkg::R_TIME;
              end
            end
          end
          msl_pkg::PH_TIME: begin
            if ((sub_count == 4'd2 || sub_count == 4'd5) ? (ch == ":")
                                                         : msl_pkg::is_digit(ch)) begin
              sub_count_next = sub_inc;
              if (sub_inc >= 4'd8) phase_next = msl_pkg::PH_ZY;
            end else begin
              fail_code = msl_pkg::R_TIME;
            end
          end
          msl_pkg::PH_ZY: begin
            if (ch != " ") begin
              if (msl_pkg::is_upper(ch)) begin
                phase_next = msl_pkg::PH_ZONE;
                sub_count_next = 4'd1;
              end else if (msl_pkg::is_digit(ch)) begin
                phase_next = msl_pkg::PH_YEAR;
                sub_count_next = 4'd1;
              end else begin
                fail_code = msl_pkg::R_YEAR;
              end
            end
          end
          msl_pkg::PH_ZONE: begin
            if (msl_pkg::is_upper(ch)) begin
              sub_count_next = sub_inc;
              if (sub_inc >= 4'd3) phase_next = msl_pkg::PH_ZONE_SP;
            end else begin
              fail_code = msl_pkg::R_YEAR;
            end
          end
          msl_pkg::PH_ZONE_SP: begin
            if (ch != " ") begin
              if (msl_pkg::is_digit(ch)) begin
                phase_next = msl_pkg::PH_YEAR;
                sub_count_next = 4'd1;
              end else begin
                fail_code = msl_pkg::R_YEAR;
              end
            end
          end
          msl_pkg::PH_YEAR: begin
            if (msl_pkg::is_digit(ch)) begin
              sub_count_next = sub_inc;
              if (sub_inc >= 4'd4) phase_next = msl_pkg::PH_TZ;
            end else begin
              fail_code = msl_pkg::R_YEAR;
            end
          end
          msl_pkg::PH_TZ: begin
            if (ch != " ") begin
              if (ch == "+" || ch == "-") begin
                phase_next = msl_pkg::PH_TZ2;
                sub_count_next = 4'd0;
              end else begin
                fail_code = msl_pkg::R_EXTRA;
              end
            end
          end
          msl_pkg::PH_TZ2: begin
            if (msl_pkg::is_digit(ch)) begin
              sub_count_next = sub_inc;
              if (sub_inc >= 4'd4) phase_next = msl_pkg::PH_TAIL;
            end else begin
              fail_code = msl_pkg::R_EXTRA;
            end
          end
          msl_pkg::PH_TAIL: begin
            if (ch != " ") fail_code = msl_pkg::R_EXTRA;
          end
          msl_pkg::PH_ART_SP: begin
            if (ch != " ") begin
              if (msl_pkg::is_digit(ch)) phase_next = msl_pkg::PH_NUM;
              else fail_code = msl_pkg::R_NUMBER;
            end
          end
          msl_pkg::PH_NUM, msl_pkg::PH_NUM_SP: begin
            // a non-space that is not a digit of the number ends it and must start "of "
            if (ch == " ") begin
              phase_next = msl_pkg::PH_NUM_SP;
            end else if (phase == msl_pkg::PH_NUM && msl_pkg::is_digit(ch)) begin
              phase_next = msl_pkg::PH_NUM;
            end else if (ch == msl_pkg::of_char(2'd0)) begin
              phase_next = msl_pkg::PH_OF;
              sub_count_next = 4'd1;
            end else begin
              fail_code = msl_pkg::R_OF;
            end
          end
          msl_pkg::PH_OF: begin
            if (ch == msl_pkg::of_char(sub_count[1:0])) begin
              sub_count_next = sub_inc;
              if (sub_inc >= 4'd3) phase_next = msl_pkg::PH_GRP_SP;
            end else begin
              fail_code = msl_pkg::R_OF;
            end
          end
          msl_pkg::PH_GRP_SP: begin
            if (ch != " ") phase_next = (ch == ":") ? msl_pkg::PH_COLON : msl_pkg::PH_GRP;
          end
          msl_pkg::PH_GRP: begin
            if (ch == ":") phase_next = msl_pkg::PH_COLON;
            else if (ch == " ") fail_code = msl_pkg::R_COLON;
          end
          msl_pkg::PH_COLON: begin
            fail_code = msl_pkg::R_COLON;
          end
          default: begin
          end
        endcase
        if (fail_code != msl_pkg::R_OK) begin
          phase_next   = msl_pkg::PH_DONE;
          failure_next = fail_code;
        end
      end
    end

    // verdict from the phase after this transaction
    case (phase_next)
      msl_pkg::PH_START, msl_pkg::PH_FROM, msl_pkg::PH_ART:
        res_reason = msl_pkg::R_PREFIX;
      msl_pkg::PH_ADDR_SP, msl_pkg::PH_ADDR, msl_pkg::PH_ADDR_POST, msl_pkg::PH_WDAY:
        res_reason = msl_pkg::R_WDAY;
      msl_pkg::PH_WDAY_SP, msl_pkg::PH_MON:
        res_reason = msl_pkg::R_MONTH;
      msl_pkg::PH_MON_SP:
        res_reason = msl_pkg::R_DAY;
      msl_pkg::PH_DAY_DIG, msl_pkg::PH_DAY_SP, msl_pkg::PH_TIME:
        res_reason = msl_pkg::R_TIME;
      msl_pkg::PH_ZY, msl_pkg::PH_ZONE, msl_pkg::PH_ZONE_SP, msl_pkg::PH_YEAR:
        res_reason = msl_pkg::R_YEAR;
      msl_pkg::PH_TZ, msl_pkg::PH_TAIL: begin
        res_reason = msl_pkg::R_OK;
        res_kind   = msl_pkg::K_MAIL;
      end
      msl_pkg::PH_TZ2:
        res_reason = msl_pkg::R_EXTRA;
      msl_pkg::PH_ART_SP:
        res_reason = msl_pkg::R_NUMBER;
      msl_pkg::PH_NUM, msl_pkg::PH_NUM_SP, msl_pkg::PH_OF:
        res_reason = msl_pkg::R_OF;
      msl_pkg::PH_GRP_SP, msl_pkg::PH_GRP:
        res_reason = msl_pkg::R_COLON;
      msl_pkg::PH_COLON: begin
        res_reason = msl_pkg::R_OK;
        res_kind   = msl_pkg::K_NEWS;
      end
      msl_pkg::PH_DONE:
        res_reason = failure_next;
      default:
        res_reason = msl_pkg::R_PREFIX;
    endcase

    // start the next line afresh
    if (in_acc && last) begin
      phase_next      = msl_pkg::PH_START;
      sub_count_next  = 4'd0;
      failure_next    = msl_pkg::R_OK;
      text_ended_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= msl_pkg::PH_START;
      sub_count  <= 4'd0;
      failure    <= msl_pkg::R_OK;
      text_ended <= 1'b0;
    end else begin
      phase      <= phase_next;
      sub_count  <= sub_count_next;
      failure    <= failure_next;
      text_ended <= text_ended_next;
    end
  end

  always_ff @(posedge clk) begin
    name_prefix <= name_prefix_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last) begin
      kind   <= res_kind;
      reason <= res_reason;
    end
  end

  a_verdict_follows_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> out_valid)
    else $error("no verdict after the last transaction of a line");

  a_kind_matches_reason: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == msl_pkg::K_LINE) == (reason != msl_pkg::R_OK)))
    else $error("verdict kind and reason disagree");

  a_done_has_failure: assert property (@(posedge clk) disable iff (rst)
    phase == msl_pkg::PH_DONE |-> failure != msl_pkg::R_OK)
    else $error("parser stopped without a failure reason");

  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=>
      phase == msl_pkg::PH_START && sub_count == 4'd0 && !text_ended)
    else $error("parser not back at line start after a verdict");

endmodule

`default_nettype wire
